### rtl/core/idri_pkg.sv
package idri_pkg;

  // Fixed-point setup
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ANG_FRAC     = 30;
  localparam int ANG_SHIFT    = ANG_FRAC - FRAC_BITS;

  // Port widths
  localparam int IN_W  = 152;
  localparam int OUT_W = 232;
  localparam int CFG_W = 32;

  // Sequencer counter and time scale sizes
  localparam int CNT_W  = 6;
  localparam int QUO_W  = 41;
  // four 32x32 partial products of the reciprocal multiply
  localparam int DIV_STEPS = 4;

  // Angle constants, Q2.30
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [35:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [35:0] X_BIAS      = 36'sd268435456;

  // Heading clamp: round(pi) at the output scale, capped to 19 bits
  localparam longint PI_RND   = (64'd3373259426 + (64'd1 << (ANG_SHIFT - 1))) >> ANG_SHIFT;
  localparam longint HEAD_MAX = (PI_RND > 262143) ? 262143 : PI_RND;
  localparam logic signed [21:0] HEAD_LIM = 22'(HEAD_MAX);

  // Time scaling: 1e9 = 2^9 * 5^9, 2e9 = 2^10 * 5^9
  localparam logic [30:0] NS_HALF1 = 31'd500000000;
  localparam logic [30:0] NS_HALF2 = 31'd1000000000;
  localparam int          NS_SH1   = 9;
  localparam int          NS_SH2   = 10;
  localparam logic [127:0] NS_ODD  = 128'd1953125;
  // ceil(2^84 / 5^9): exact quotient for any dividend below 2^63
  localparam int          RCP_SHIFT = 84;
  localparam logic [127:0] RCP_FULL =
    ((128'd1 << RCP_SHIFT) + NS_ODD - 128'd1) / NS_ODD;
  localparam logic [63:0] RCP_M    = 64'(RCP_FULL);
  // shifted dividend at or above this gives a quotient beyond the cap
  localparam logic [96:0] OVF_LIM  = 97'(((128'd1 << 40) + 128'd1) * NS_ODD);
  localparam logic [QUO_W-1:0] SCALE_CAP = QUO_W'(1) << 40;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SPEED   = 1'b0,
    CFG_HEADING = 1'b1
  } idri_cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_VEC_INIT,
    ST_VEC_STEP,
    ST_YAW,
    ST_SC_LOAD,
    ST_SC_MUL0,
    ST_SC_MUL1,
    ST_SC_MUL2,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_SC_APPLY,
    ST_ROT_INIT,
    ST_ROT_STEP,
    ST_TRK_X,
    ST_TRK_AX,
    ST_TRK_AY,
    ST_EMIT
  } idri_state_e;

  // Controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       first;
    logic       prep;
    logic       vec_init;
    logic       vec_step;
    logic       yaw;
    logic       sc_load;
    logic       sc_mul0;
    logic       sc_mul1;
    logic       sc_mul2;
    logic       div_init;
    logic       div_step;
    logic       sc_apply;
    logic       pass;
    logic       rot_init;
    logic       rot_step;
    logic       trk_x;
    logic       trk_ax;
    logic       trk_ay;
    logic       emit;
    logic [4:0] iter;
  } idri_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic have_prev;
  } idri_sts_t;

  // Arctangent table, Q2.30, truncated
  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
    logic signed [31:0] r;
    if (v > 43'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -43'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    logic signed [39:0] r;
    if (v > 41'sd549755813887) begin
      r = 40'sh7fffffffff;
    end else if (v < -41'sd549755813888) begin
      r = 40'sh8000000000;
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/idri_ctrl.sv
module idri_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_kind_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  idri_pkg::idri_sts_t   sts_i,
  output idri_pkg::idri_cmd_t   cmd_o
);
  import idri_pkg::*;

  idri_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              pass_q, pass_d;
  logic              oval_q, oval_d;
  logic              in_fire;
  logic              out_free;
  logic              cordic_last;
  logic              div_last;

  assign in_fire     = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !oval_q || out_ready_i;
  assign cordic_last = (cnt_q == CNT_W'(CORDIC_STEPS - 1));
  assign div_last    = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_kind_i) begin
            state_d = ST_ROT_INIT;
          end else if (sts_i.have_prev) begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP:     state_d = ST_VEC_INIT;
      ST_VEC_INIT: state_d = ST_VEC_STEP;
      ST_VEC_STEP: if (cordic_last) state_d = ST_YAW;
      ST_YAW:      state_d = ST_SC_LOAD;
      ST_SC_LOAD:  state_d = ST_SC_MUL0;
      ST_SC_MUL0:  state_d = ST_SC_MUL1;
      ST_SC_MUL1:  state_d = ST_SC_MUL2;
      ST_SC_MUL2:  state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = ST_DIV_STEP;
      ST_DIV_STEP: if (div_last) state_d = ST_SC_APPLY;
      ST_SC_APPLY: state_d = pass_q ? ST_IDLE : ST_SC_LOAD;
      ST_ROT_INIT: state_d = ST_ROT_STEP;
      ST_ROT_STEP: if (cordic_last) state_d = ST_TRK_X;
      ST_TRK_X:    state_d = ST_TRK_AX;
      ST_TRK_AX:   state_d = ST_TRK_AY;
      ST_TRK_AY:   state_d = ST_EMIT;
      ST_EMIT:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Counter, pass select and output valid
  always_comb begin
    cnt_d  = (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
    pass_d = (state_q == ST_SC_APPLY) ? !pass_q : pass_q;
    oval_d = oval_q;
    if ((state_q == ST_EMIT) && out_free) begin
      oval_d = 1'b1;
    end else if (out_ready_i) begin
      oval_d = 1'b0;
    end
  end

  // Commands
  always_comb begin
    cmd_o          = '0;
    cmd_o.iter     = cnt_q[4:0];
    cmd_o.pass     = pass_q;
    cmd_o.load_in  = in_fire;
    cmd_o.first    = in_fire && !in_kind_i && !sts_i.have_prev;
    cmd_o.prep     = (state_q == ST_PREP);
    cmd_o.vec_init = (state_q == ST_VEC_INIT);
    cmd_o.vec_step = (state_q == ST_VEC_STEP);
    cmd_o.yaw      = (state_q == ST_YAW);
    cmd_o.sc_load  = (state_q == ST_SC_LOAD);
    cmd_o.sc_mul0  = (state_q == ST_SC_MUL0);
    cmd_o.sc_mul1  = (state_q == ST_SC_MUL1);
    cmd_o.sc_mul2  = (state_q == ST_SC_MUL2);
    cmd_o.div_init = (state_q == ST_DIV_INIT);
    cmd_o.div_step = (state_q == ST_DIV_STEP);
    cmd_o.sc_apply = (state_q == ST_SC_APPLY);
    cmd_o.rot_init = (state_q == ST_ROT_INIT);
    cmd_o.rot_step = (state_q == ST_ROT_STEP);
    cmd_o.trk_x    = (state_q == ST_TRK_X);
    cmd_o.trk_ax   = (state_q == ST_TRK_AX);
    cmd_o.trk_ay   = (state_q == ST_TRK_AY);
    cmd_o.emit     = (state_q == ST_EMIT) && out_free;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = oval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      pass_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
      oval_q  <= oval_d;
    end
  end

endmodule

### rtl/core/idri_dp.sv
module idri_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  idri_pkg::idri_cmd_t           cmd_i,
  output idri_pkg::idri_sts_t           sts_o,
  input  logic [idri_pkg::IN_W-1:0]     in_data_i,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [idri_pkg::CFG_W-1:0]    cfg_data_i,
  output logic [idri_pkg::OUT_W-1:0]    out_data_o
);
  import idri_pkg::*;

  // Architectural state
  logic               have_prev_q;
  logic [62:0]        prev_time_q;
  logic signed [31:0] vel_q;
  logic signed [31:0] dist_q;
  logic signed [18:0] cur_head_q;
  logic signed [19:0] prev_head_q;
  logic signed [39:0] pos_x_q, pos_y_q;
  logic [15:0]        count_q;

  // Captured item and working registers
  logic [62:0]        t_q;
  logic signed [23:0] accel_q;
  logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
  logic [62:0]        dt_q;
  logic signed [31:0] p_wz_q, p_yx_q, p_xx_q, p_zz_q;
  logic signed [35:0] x_q, y_q;
  logic signed [33:0] z_q;
  logic               zero_q, flip_q;
  logic signed [31:0] vnew_q;
  logic [32:0]        m_q;
  logic               neg_q;
  logic [64:0]        prod_q;
  logic [96:0]        acc_q;
  logic               ovf_q;
  logic [63:0]        dvd_q;
  logic [127:0]       rcp_q;
  logic signed [63:0] mp_q;
  logic [OUT_W-1:0]   out_q;

  // Combinational next values
  logic [62:0]        dt_d;
  logic signed [35:0] ysum, xsum, y0, x0;
  logic signed [35:0] vx_d, vy_d;
  logic signed [33:0] vz_d;
  logic signed [35:0] xs, ys;
  logic signed [33:0] at;
  logic signed [35:0] xn_d, yn_d;
  logic signed [33:0] zn_d;
  logic [33:0]        amag;
  logic [34:0]        arnd;
  logic signed [21:0] ang_r, ang_c;
  logic signed [18:0] head_d;
  logic signed [32:0] msrc;
  logic [30:0]        half_d;
  logic [96:0]        nsh_d;
  logic [31:0]        pa, pb;
  logic [63:0]        pp;
  logic [127:0]       pp_sh;
  logic [QUO_W-1:0]   quo_d;
  logic [QUO_W-1:0]   tsmag;
  logic signed [41:0] ts_d;
  logic signed [42:0] ssum;
  logic signed [31:0] ssat_d;
  logic signed [33:0] zh, rz_d;
  logic               rflip_d;
  logic signed [35:0] c_d, s_d;
  logic signed [31:0] c32, s32;
  logic signed [63:0] mpc_d, mps_d;
  logic [63:0]        mmag;
  logic [63:0]        mrnd;
  logic signed [34:0] term_d;
  logic signed [40:0] psum_x, psum_y;
  logic signed [19:0] dh_d;

  assign sts_o.have_prev = have_prev_q;

  // Elapsed time, clipped at zero when time runs backwards
  assign dt_d = (t_q >= prev_time_q) ? (t_q - prev_time_q) : '0;

  // Yaw vector and quarter-turn prerotation
  always_comb begin
    ysum = 36'(p_wz_q) + 36'(p_yx_q);
    xsum = 36'(p_xx_q) + 36'(p_zz_q);
    y0   = ysum <<< 1;
    x0   = X_BIAS - (xsum <<< 1);
    vx_d = x0;
    vy_d = y0;
    vz_d = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        vx_d = y0;
        vy_d = -x0;
        vz_d = HALF_PI_Q30;
      end else begin
        vx_d = -y0;
        vy_d = x0;
        vz_d = -HALF_PI_Q30;
      end
    end
  end

  // One CORDIC iteration, vectoring or rotation
  always_comb begin
    xs = x_q >>> cmd_i.iter;
    ys = y_q >>> cmd_i.iter;
    at = atan_q30(cmd_i.iter);
    if (cmd_i.vec_step) begin
      if (y_q > 0) begin
        xn_d = x_q + ys;
        yn_d = y_q - xs;
        zn_d = z_q + at;
      end else begin
        xn_d = x_q - ys;
        yn_d = y_q + xs;
        zn_d = z_q - at;
      end
    end else begin
      if (z_q >= 0) begin
        xn_d = x_q - ys;
        yn_d = y_q + xs;
        zn_d = z_q - at;
      end else begin
        xn_d = x_q + ys;
        yn_d = y_q - xs;
        zn_d = z_q + at;
      end
    end
  end

  // Angle rounding to output scale and clamp
  always_comb begin
    amag  = (z_q < 0) ? 34'(-z_q) : 34'(z_q);
    arnd  = (35'(amag) + (35'(1) << (ANG_SHIFT - 1))) >> ANG_SHIFT;
    ang_r = (z_q < 0) ? -22'(arnd) : 22'(arnd);
    ang_c = ang_r;
    if (ang_r > HEAD_LIM) ang_c = HEAD_LIM;
    if (ang_r < -HEAD_LIM) ang_c = -HEAD_LIM;
    head_d = zero_q ? '0 : ang_c[18:0];
  end

  // Time scale unit: operand, power-of-two prescale, reciprocal multiply
  always_comb begin
    msrc   = cmd_i.pass ? (33'(vel_q) + 33'(vnew_q)) : 33'(accel_q);
    half_d = cmd_i.pass ? NS_HALF2 : NS_HALF1;
    nsh_d  = cmd_i.pass ? (acc_q >> NS_SH2) : (acc_q >> NS_SH1);
    // partial product select: iter bit 0 picks the dividend half,
    // iter bit 1 the reciprocal half; weight is 32 times their sum
    pa     = cmd_i.iter[0] ? dvd_q[63:32] : dvd_q[31:0];
    pb     = cmd_i.iter[1] ? RCP_M[63:32] : RCP_M[31:0];
    pp     = 64'(pa) * 64'(pb);
    pp_sh  = 128'(pp) << {cmd_i.iter[1] & cmd_i.iter[0],
                          cmd_i.iter[1] ^ cmd_i.iter[0], 5'b00000};
    quo_d  = rcp_q[RCP_SHIFT +: QUO_W];
    tsmag  = (ovf_q || (quo_d > SCALE_CAP)) ? SCALE_CAP : quo_d;
    ts_d   = neg_q ? -$signed({1'b0, tsmag}) : $signed({1'b0, tsmag});
    ssum   = cmd_i.pass ? (43'(dist_q) + 43'(ts_d)) : (43'(vel_q) + 43'(ts_d));
    ssat_d = sat32(ssum);
  end

  // Heading to rotation angle, half-turn reduction
  always_comb begin
    zh      = 34'(cur_head_q) <<< ANG_SHIFT;
    rz_d    = zh;
    rflip_d = 1'b0;
    if (zh > HALF_PI_Q30) begin
      rz_d    = zh - PI_Q30;
      rflip_d = 1'b1;
    end else if (zh < -HALF_PI_Q30) begin
      rz_d    = zh + PI_Q30;
      rflip_d = 1'b1;
    end
  end

  // Track step products and rounding
  always_comb begin
    c_d    = flip_q ? -x_q : x_q;
    s_d    = flip_q ? -y_q : y_q;
    c32    = c_d[31:0];
    s32    = s_d[31:0];
    mpc_d  = dist_q * c32;
    mps_d  = dist_q * s32;
    mmag   = (mp_q < 0) ? 64'(-mp_q) : 64'(mp_q);
    mrnd   = (mmag + (64'd1 << (ANG_FRAC - 1))) >> ANG_FRAC;
    term_d = (mp_q < 0) ? -35'(mrnd[33:0]) : 35'(mrnd[33:0]);
    psum_x = 41'(pos_x_q) + 41'(term_d);
    psum_y = 41'(pos_y_q) + 41'(term_d);
    dh_d   = 20'(cur_head_q) - prev_head_q;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      prev_time_q <= '0;
      vel_q       <= 32'sd353894;
      dist_q      <= '0;
      cur_head_q  <= '0;
      prev_head_q <= 20'sd114033;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (idri_cfg_e'(cfg_idx_i))
          CFG_SPEED:   vel_q <= cfg_data_i;
          CFG_HEADING: prev_head_q <= 20'($signed(cfg_data_i[18:0]));
          default: ;
        endcase
      end
      if (cmd_i.first) begin
        have_prev_q <= 1'b1;
        prev_time_q <= in_data_i[62:0];
      end
      if (cmd_i.prep) prev_time_q <= t_q;
      if (cmd_i.yaw) cur_head_q <= head_d;
      if (cmd_i.sc_apply) begin
        if (cmd_i.pass) begin
          dist_q <= ssat_d;
          vel_q  <= vnew_q;
        end
      end
      if (cmd_i.trk_ax) pos_x_q <= sat40(psum_x);
      if (cmd_i.trk_ay) pos_y_q <= sat40(psum_y);
      if (cmd_i.emit) begin
        count_q     <= count_q + 16'd1;
        dist_q      <= '0;
        prev_head_q <= 20'(cur_head_q);
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      t_q     <= in_data_i[62:0];
      accel_q <= in_data_i[86:63];
      qw_q    <= in_data_i[102:87];
      qx_q    <= in_data_i[118:103];
      qy_q    <= in_data_i[134:119];
      qz_q    <= in_data_i[150:135];
    end
    if (cmd_i.prep) begin
      dt_q   <= dt_d;
      p_wz_q <= qw_q * qz_q;
      p_yx_q <= qy_q * qx_q;
      p_xx_q <= qx_q * qx_q;
      p_zz_q <= qz_q * qz_q;
    end
    if (cmd_i.vec_init) begin
      x_q    <= vx_d;
      y_q    <= vy_d;
      z_q    <= vz_d;
      zero_q <= (x0 == 0) && (y0 == 0);
    end
    if (cmd_i.vec_step || cmd_i.rot_step) begin
      x_q <= xn_d;
      y_q <= yn_d;
      z_q <= zn_d;
    end
    if (cmd_i.rot_init) begin
      x_q    <= GAIN_Q30;
      y_q    <= '0;
      z_q    <= rz_d;
      flip_q <= rflip_d;
    end
    if (cmd_i.sc_load) begin
      neg_q <= (msrc < 0);
      m_q   <= (msrc < 0) ? 33'(-msrc) : 33'(msrc);
    end
    if (cmd_i.sc_mul0) prod_q <= m_q * dt_q[31:0];
    if (cmd_i.sc_mul1) begin
      acc_q  <= 97'(prod_q) + 97'(half_d);
      prod_q <= m_q * dt_q[62:32];
    end
    if (cmd_i.sc_mul2) acc_q <= acc_q + (97'(prod_q) << 32);
    // after the prescale a non-capped dividend is below 2^62
    if (cmd_i.div_init) begin
      ovf_q <= (nsh_d >= OVF_LIM);
      dvd_q <= nsh_d[63:0];
      rcp_q <= '0;
    end
    if (cmd_i.div_step) rcp_q <= rcp_q + pp_sh;
    if (cmd_i.sc_apply && !cmd_i.pass) vnew_q <= ssat_d;
    if (cmd_i.trk_x) mp_q <= mpc_d;
    if (cmd_i.trk_ax) mp_q <= mps_d;
    if (cmd_i.emit) begin
      out_q <= {2'b00, prev_time_q, pos_y_q, pos_x_q, cur_head_q, dh_d, dist_q, count_q};
    end
  end

  assign out_data_o = out_q;

endmodule

### rtl/core/imu_dead_reckoning_integrator.sv
// Channel   Dir  tdata (low bit up)                                     tuser
// s_axis    in   sample_time_ns 63, accel_forward 24, quat_w/x/y/z 16   operation
// m_axis    out  pose_index 16, delta_forward 32, delta_heading 20,     -
//                heading 19, track_x 40, track_y 40, stamp_ns 63
// cfg       in   cfg_idx_i selects initial_speed (0) / initial_heading (1)
//
// The first sample after reset only records its time stamp. Later samples run
// a 16-step atan2 CORDIC followed by two passes of the time scale unit (partial
// multiplies by the elapsed time and a four-step reciprocal multiply each), one
// for velocity and one for distance. Boundaries run a 16-step sin/cos CORDIC
// plus two track multiplies, then wait to emit while the previous result is
// still held. Result sits in an output register, so the next item is taken while
// it waits. Reset loads defaults into the architectural state at once.
module imu_dead_reckoning_integrator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // sample_time_ns, accel_forward, quat_w, quat_x, quat_y, quat_z, pad
  input  logic [idri_pkg::IN_W-1:0]   s_axis_tdata,
  // operation
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // pose_index, delta_forward, delta_heading, heading, track_x, track_y,
  // stamp_ns, pad
  output logic [idri_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [idri_pkg::CFG_W-1:0]  cfg_data_i
);
  import idri_pkg::*;

  idri_cmd_t cmd;
  idri_sts_t sts;

  idri_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  idri_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (m_axis_tdata)
  );

endmodule

### rtl/core/idri_chk.sv
module idri_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        s_axis_tuser,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [idri_pkg::OUT_W-1:0]  m_axis_tdata
);

  // Held result stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // Held result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result payload changed while stalled");

  // A boundary beat starts a multi-cycle job
  a_bound_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("input taken during boundary work");

  // A new result only appears from boundary work
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without boundary work");

endmodule

bind imu_dead_reckoning_integrator idri_chk u_idri_chk (.*);

### tb/imu_dead_reckoning_integrator_tb.sv
`timescale 1ns / 100ps

module imu_dead_reckoning_integrator_tb;
  import idri_pkg::*;

  localparam int         WATCHDOG_LIMIT = 20000;
  localparam int         DRAIN_CYCLES   = 150;
  localparam longint     CAP            = 64'sd1 << 40;
  localparam longint     PI_ANG         = 64'sd3373259426;
  localparam longint     HALF_PI_ANG    = 64'sd1686629713;
  localparam longint     CORDIC_GAIN    = 64'sd652032874;
  localparam longint unsigned NS_SEC    = 64'd1000000000;

  // One boundary report
  typedef struct {
    logic [15:0]        pose_index;
    logic signed [31:0] delta_forward;
    logic signed [19:0] delta_heading;
    logic signed [18:0] heading;
    logic signed [39:0] track_x;
    logic signed [39:0] track_y;
    logic [62:0]        stamp_ns;
  } pose_report_t;

  // Dead-reckoning predictor plus the queue of expected pose reports
  class pose_scoreboard;
    pose_report_t       pose_q[$];
    int                 errors;
    bit                 have_prev;
    logic [62:0]        prev_time;
    longint             vel, dist_acc, cur_head, prev_head, pos_x, pos_y;
    logic [15:0]        bnd_count;
    longint             atan_tab[16] = '{843314856, 497837829, 263043836, 133525158,
      67021686, 33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767};

    function new();
      errors = 0;
      have_prev = 0;
      prev_time = '0;
      vel = 353894;
      dist_acc = 0;
      cur_head = 0;
      prev_head = 114033;
      pos_x = 0;
      pos_y = 0;
      bnd_count = '0;
    endfunction

    function void write_reg(idri_cfg_e idx, logic [31:0] val);
      logic signed [18:0] h;
      h = val[18:0];
      if (idx == CFG_SPEED) vel = longint'($signed(val));
      else prev_head = longint'(h);
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint rnd_shift(longint v, int k);
      longint unsigned m;
      m = (mag(v) + (64'd1 << (k - 1))) >> k;
      return v < 0 ? -longint'(m) : longint'(m);
    endfunction

    function longint sat(longint v, int bits);
      longint hi;
      hi = (longint'(1) << (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    // round(s * dt / div), magnitude capped
    function longint scale_dt(longint s, longint unsigned dt, longint unsigned div);
      longint unsigned m, q, r, res;
      m = mag(s);
      q = dt / div;
      r = dt % div;
      if (m == 0) return 0;
      if (q > CAP / m) res = CAP;
      else begin
        res = m * q + (m * r + div / 2) / div;
        if (res > CAP) res = CAP;
      end
      return s < 0 ? -longint'(res) : longint'(res);
    endfunction

    // atan2 by vectoring CORDIC, result in Q.16
    function longint yaw(longint y, longint x);
      longint ang, t, xs, ys, lim;
      ang = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        if (y >= 0) begin
          t = x; x = y; y = -t; ang = HALF_PI_ANG;
        end else begin
          t = x; x = -y; y = t; ang = -HALF_PI_ANG;
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; ang += atan_tab[i];
        end else begin
          x -= ys; y += xs; ang -= atan_tab[i];
        end
      end
      ang = rnd_shift(ang, ANG_SHIFT);
      lim = rnd_shift(PI_ANG, ANG_SHIFT);
      if (lim > 262143) lim = 262143;
      if (ang > lim) ang = lim;
      if (ang < -lim) ang = -lim;
      return ang;
    endfunction

    // rotation CORDIC, Q2.30 cos and sin
    function void rotate(longint h, output longint c, output longint s);
      longint z, x, y, xs, ys;
      bit flip;
      z = h * (longint'(1) << ANG_SHIFT);
      x = CORDIC_GAIN;
      y = 0;
      flip = 0;
      if (z > HALF_PI_ANG) begin
        z -= PI_ANG; flip = 1;
      end else if (z < -HALF_PI_ANG) begin
        z += PI_ANG; flip = 1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tab[i];
        end else begin
          x += ys; y -= xs; z += atan_tab[i];
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // note one accepted input beat
    function void note_input(logic op, logic [IN_W-1:0] d);
      logic [62:0]        t;
      logic signed [23:0] acc;
      logic signed [15:0] qw, qx, qy, qz;
      longint unsigned    dt;
      longint             w, x, y, z, vnew, c, s;
      pose_report_t       rep;
      t   = d[62:0];
      acc = d[86:63];
      qw  = d[102:87];
      qx  = d[118:103];
      qy  = d[134:119];
      qz  = d[150:135];
      if (op == 1'b0) begin
        if (!have_prev) begin
          have_prev = 1;
          prev_time = t;
          return;
        end
        dt = (t >= prev_time) ? longint'(t - prev_time) : 0;
        prev_time = t;
        w = qw; x = qx; y = qy; z = qz;
        cur_head = yaw(2 * (w * z + y * x), (longint'(1) << 28) - 2 * (x * x + z * z));
        vnew = sat(vel + scale_dt(longint'(acc), dt, NS_SEC), 32);
        dist_acc = sat(dist_acc + scale_dt(vel + vnew, dt, 2 * NS_SEC), 32);
        vel = vnew;
      end else begin
        rotate(cur_head, c, s);
        pos_x = sat(pos_x + rnd_shift(dist_acc * c, ANG_FRAC), 40);
        pos_y = sat(pos_y + rnd_shift(dist_acc * s, ANG_FRAC), 40);
        rep.pose_index    = bnd_count;
        rep.delta_forward = dist_acc[31:0];
        rep.delta_heading = 20'(cur_head - prev_head);
        rep.heading       = cur_head[18:0];
        rep.track_x       = pos_x[39:0];
        rep.track_y       = pos_y[39:0];
        rep.stamp_ns      = prev_time;
        pose_q = {pose_q, rep};
        bnd_count++;
        dist_acc = 0;
        prev_head = cur_head;
      end
    endfunction

    function void field_check(string name, longint e, longint a);
      if (e != a) begin
        $display("%0t: %s expected %0d got %0d", $time, name, e, a);
        errors++;
      end
    endfunction

    // compare one output beat against the oldest expected report
    function void check_result(logic [OUT_W-1:0] d);
      pose_report_t e;
      logic [62:0]  st;
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected pose beat expected none got %h", $time, d);
        errors++;
        return;
      end
      e = pose_q.pop_front();
      st = d[229:167];
      field_check("pose_index", e.pose_index, d[15:0]);
      field_check("delta_forward", e.delta_forward, $signed(d[47:16]));
      field_check("delta_heading", e.delta_heading, $signed(d[67:48]));
      field_check("heading", e.heading, $signed(d[86:68]));
      field_check("track_x", e.track_x, $signed(d[126:87]));
      field_check("track_y", e.track_y, $signed(d[166:127]));
      field_check("stamp_ns", longint'(e.stamp_ns), longint'(st));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             cfg_we_i = 1'b0;
  logic             cfg_idx_i = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  pose_scoreboard   sb = new();
  bit               calm = 0;
  int               quiet_cycles = 0;
  logic [62:0]      now_ns = '0;

  imu_dead_reckoning_integrator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // result sink: random backpressure
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // watchdog on accepted beats
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // drive one beat, with random gaps before it
  task automatic send_beat(logic op, logic [62:0] t, logic [23:0] acc,
                           logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                           logic [15:0] qz);
    logic [IN_W-1:0] d;
    d = {1'b0, qz, qy, qx, qw, acc, t};
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(op, d);
  endtask

  task automatic boundary();
    send_beat(1'b1, 63'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom));
  endtask

  task automatic sample(logic [62:0] t, logic [23:0] acc, logic [15:0] qw,
                        logic [15:0] qx, logic [15:0] qy, logic [15:0] qz);
    now_ns = t;
    send_beat(1'b0, t, acc, qw, qx, qy, qz);
  endtask

  function automatic logic [15:0] rand_quat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'($urandom);
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  // let the block go idle, then write a register
  task automatic write_reg(idri_cfg_e idx, logic [31:0] val);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pose_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // mostly forward-moving samples with boundaries sprinkled in
  task automatic random_run(int n);
    logic [62:0] t;
    int          r;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3) && (i < n / 3 + 100);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        boundary();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) t = (now_ns > 5000) ? now_ns - 63'($urandom_range(1, 5000)) : 0;
        else if (r < 5) t = now_ns + 63'({$urandom(), $urandom()} % (64'd1 << 42));
        else if (r < 6) t = 63'({$urandom(), $urandom()});
        else t = now_ns + 63'($urandom_range(0, 20000000));
        if ($urandom_range(0, 99) < 5) begin
          sample(t, 24'($urandom), 16'($urandom), 16'd0, 16'd0, 16'd0);
        end else begin
          sample(t, 24'($urandom), rand_quat(), rand_quat(), rand_quat(), rand_quat());
        end
      end
    end
    calm = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: report with no sample yet, first sample, extremes
    boundary();
    sample(63'd0, 24'h7fffff, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    boundary();
    sample(63'd10000000, 24'h7fffff, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    sample(63'd30000000, 24'h800000, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    boundary();
    // time going backwards
    sample(63'd20000000, 24'h123456, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    // vector with x = y = 0
    sample(63'd40000000, 24'h000100, 16'sd0, 16'sd8192, 16'sd0, 16'sd8192);
    boundary();
    // raw bit-pattern extremes
    sample(63'd50000000, 24'h000000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    sample(63'd60000000, 24'h7fffff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    sample(63'd60000000, 24'hffffff, -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
    // huge gap saturates speed and distance
    sample(63'h3fffffffffff, 24'h7fffff, 16'sd16384, 16'sd0, 16'sd0, -16'sd100);
    boundary();
    sample(63'h7fffffffffffffff, 24'h800000, 16'sd100, 16'sd0, 16'sd0, 16'sd16384);
    boundary();
    sample(63'h7fffffffffffffff, 24'h000001, -16'sd16384, 16'sd0, 16'sd0, -16'sd16384);
    boundary();
    now_ns = 63'd100000000;
    random_run(500);

    // register extremes
    write_reg(CFG_SPEED, 32'h7fffffff);
    write_reg(CFG_HEADING, 32'(-205887));
    random_run(400);
    write_reg(CFG_SPEED, 32'h80000000);
    write_reg(CFG_HEADING, 32'd205887);
    random_run(400);
    write_reg(CFG_SPEED, 32'($urandom_range(0, 1000000)) - 32'd500000);
    write_reg(CFG_HEADING, 32'h7ffff);
    random_run(400);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pose_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/idri_pkg.sv
rtl/core/idri_ctrl.sv
rtl/core/idri_dp.sv
rtl/core/imu_dead_reckoning_integrator.sv
rtl/core/idri_chk.sv
tb/imu_dead_reckoning_integrator_tb.sv
